// ----- src/kci_pkg.sv -----
// ----------------------------------------------------------------------------
// kci_pkg
// Shared widths, pipeline payload types and arithmetic helpers for the
// keyframe cubic interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

    localparam int VAL_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int COEF_W     = 62 - FRAC_BITS;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PX_W       = COEF_W + FRAC_W + 1;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
    localparam logic signed [PX_W-1:0] ROUND_HALF = PX_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [COEF_W+1:0] wide_t;

    typedef struct packed {
        logic [PROD_W-1:0] num;
        logic [DIFF_W-1:0] den;
        logic [DIFF_W-1:0] rem;
        logic [PROD_W-1:0] quo;
        logic              neg;
        logic              used;
        logic              zero;
    } div_t;

    typedef struct packed {
        div_t                     s1;
        div_t                     s2;
        logic signed [DIFF_W-1:0] delta;
        logic signed [VAL_W-1:0]  start;
        logic [FRAC_W-1:0]        x;
    } div_item_t;

    typedef struct packed {
        coef_t             acc;
        coef_t             b;
        coef_t             c;
        coef_t             d;
        logic [FRAC_W-1:0] x;
        logic              fault;
    } horner_t;

    function automatic coef_t sat_coef(wide_t v);
        coef_t r;
        if (v > wide_t'({1'b0, {(COEF_W-1){1'b1}}}))
            r = {1'b0, {(COEF_W-1){1'b1}}};
        else if (v < $signed({{3{1'b1}}, {(COEF_W-1){1'b0}}}))
            r = {1'b1, {(COEF_W-1){1'b0}}};
        else
            r = v[COEF_W-1:0];
        return r;
    endfunction

    function automatic coef_t cadd(coef_t a, coef_t b);
        wide_t s;
        s = wide_t'(a) + wide_t'(b);
        return sat_coef(s);
    endfunction

    function automatic coef_t csub(coef_t a, coef_t b);
        wide_t s;
        s = wide_t'(a) - wide_t'(b);
        return sat_coef(s);
    endfunction

    // one restoring division step
    function automatic div_t div_step(div_t s);
        logic [DIFF_W:0] rr;
        div_t            r;
        r = s;
        rr = {s.rem, s.num[PROD_W-1]};
        r.num = {s.num[PROD_W-2:0], 1'b0};
        if (rr >= {1'b0, s.den})
        begin
            r.rem = DIFF_W'(rr - {1'b0, s.den});
            r.quo = {s.quo[PROD_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = rr[DIFF_W-1:0];
            r.quo = {s.quo[PROD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // signed, saturated slope from the finished quotient
    function automatic coef_t slope_final(div_t s);
        logic  hi;
        coef_t q;
        coef_t r;
        hi = |s.quo[PROD_W-1:COEF_W];
        q  = s.quo[COEF_W-1:0];
        if (!s.used || s.zero)
            r = '0;
        else if (!s.neg)
            r = (hi || q[COEF_W-1]) ? {1'b0, {(COEF_W-1){1'b1}}} : q;
        else if (hi || (q[COEF_W-1] && |q[COEF_W-2:0]))
            r = {1'b1, {(COEF_W-1){1'b0}}};
        else
            r = -q;
        return r;
    endfunction

endpackage

// ----- src/kci_prep.sv -----
// ----------------------------------------------------------------------------
// kci_prep
// Differences, magnitudes and the two slope numerator products (two stages).
// ----------------------------------------------------------------------------
module kci_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_prev,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_start,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_end,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_next,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_prev,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_start,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_end,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_next,
    input  logic                              has_prev,
    input  logic                              has_next,
    input  logic [kci_pkg::FRAC_W-1:0]        frac,
    output logic                              out_valid,
    input  logic                              out_ready,
    output kci_pkg::div_item_t                out_data
);
    import kci_pkg::*;

    typedef struct packed {
        logic [DIFF_W-1:0]        mdv1;
        logic [DIFF_W-1:0]        mdv2;
        logic [DIFF_W-1:0]        mdt;
        logic [DIFF_W-1:0]        den1;
        logic [DIFF_W-1:0]        den2;
        logic                     neg1;
        logic                     neg2;
        logic                     zero1;
        logic                     zero2;
        logic                     hp;
        logic                     hn;
        logic signed [DIFF_W-1:0] delta;
        logic signed [VAL_W-1:0]  start;
        logic [FRAC_W-1:0]        x;
    } prep_t;

    function automatic logic [DIFF_W-1:0] mag(logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    logic                     a_valid_reg;
    prep_t                    a_reg;
    prep_t                    a_next;
    logic                     a_ready;
    logic                     b_valid_reg;
    div_item_t                b_reg;
    div_item_t                b_next;
    logic signed [DIFF_W-1:0] dt;
    logic signed [DIFF_W-1:0] dv1;
    logic signed [DIFF_W-1:0] dv2;
    logic signed [DIFF_W-1:0] dtn1;
    logic signed [DIFF_W-1:0] dtn2;

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;
    assign a_ready   = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || a_ready;

    always_comb
    begin
        dt   = DIFF_W'(time_end) - DIFF_W'(time_start);
        dv1  = DIFF_W'(value_end) - DIFF_W'(value_prev);
        dtn1 = DIFF_W'(time_end) - DIFF_W'(time_prev);
        dv2  = DIFF_W'(value_next) - DIFF_W'(value_start);
        dtn2 = DIFF_W'(time_next) - DIFF_W'(time_start);
        a_next.mdv1  = mag(dv1);
        a_next.mdv2  = mag(dv2);
        a_next.mdt   = mag(dt);
        a_next.zero1 = (dtn1 == '0);
        a_next.zero2 = (dtn2 == '0);
        // keep the divisor nonzero so the divider stays well defined
        a_next.den1  = a_next.zero1 ? DIFF_W'(1) : mag(dtn1);
        a_next.den2  = a_next.zero2 ? DIFF_W'(1) : mag(dtn2);
        a_next.neg1  = dv1[DIFF_W-1] ^ dt[DIFF_W-1] ^ dtn1[DIFF_W-1];
        a_next.neg2  = dv2[DIFF_W-1] ^ dt[DIFF_W-1] ^ dtn2[DIFF_W-1];
        a_next.hp    = has_prev;
        a_next.hn    = has_next;
        a_next.delta = DIFF_W'(value_end) - DIFF_W'(value_start);
        a_next.start = value_start;
        a_next.x     = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    end

    always_comb
    begin
        b_next.s1.num  = a_reg.mdv1 * a_reg.mdt;
        b_next.s1.den  = a_reg.den1;
        b_next.s1.rem  = '0;
        b_next.s1.quo  = '0;
        b_next.s1.neg  = a_reg.neg1;
        b_next.s1.used = a_reg.hp;
        b_next.s1.zero = a_reg.zero1;
        b_next.s2.num  = a_reg.mdv2 * a_reg.mdt;
        b_next.s2.den  = a_reg.den2;
        b_next.s2.rem  = '0;
        b_next.s2.quo  = '0;
        b_next.s2.neg  = a_reg.neg2;
        b_next.s2.used = a_reg.hn;
        b_next.s2.zero = a_reg.zero2;
        b_next.delta   = a_reg.delta;
        b_next.start   = a_reg.start;
        b_next.x       = a_reg.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (a_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            a_reg <= a_next;
        if (a_ready && a_valid_reg)
            b_reg <= b_next;
    end

endmodule

// ----- src/kci_div_stage.sv -----
// ----------------------------------------------------------------------------
// kci_div_stage
// One stage of the pipelined slope divider: a few quotient bits per slope.
// ----------------------------------------------------------------------------
module kci_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kci_pkg::div_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kci_pkg::div_item_t out_data
);
    import kci_pkg::*;

    logic      valid_reg;
    div_item_t data_reg;
    div_item_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            data_next.s1 = div_step(data_next.s1);
            data_next.s2 = div_step(data_next.s2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- src/kci_coef.sv -----
// ----------------------------------------------------------------------------
// kci_coef
// Slope saturation and polynomial coefficients for the four curve forms.
// ----------------------------------------------------------------------------
module kci_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kci_pkg::div_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kci_pkg::horner_t   out_data
);
    import kci_pkg::*;

    typedef struct packed {
        coef_t             s1;
        coef_t             s2;
        coef_t             delta;
        coef_t             start;
        coef_t             t1;
        coef_t             t2;
        coef_t             bl;
        coef_t             br;
        coef_t             a3;
        coef_t             cr;
        logic              hp;
        logic              hn;
        logic              fault;
        logic [FRAC_W-1:0] x;
    } cf_t;

    logic    v1_reg;
    logic    v2_reg;
    logic    v3_reg;
    logic    v4_reg;
    logic    r2;
    logic    r3;
    logic    r4;
    cf_t     c1_reg;
    cf_t     c1_next;
    cf_t     c2_reg;
    cf_t     c2_next;
    cf_t     c3_reg;
    cf_t     c3_next;
    horner_t h_reg;
    horner_t h_next;
    coef_t   bc;

    assign r4        = !v4_reg || out_ready;
    assign r3        = !v3_reg || r4;
    assign r2        = !v2_reg || r3;
    assign in_ready  = !v1_reg || r2;
    assign out_valid = v4_reg;
    assign out_data  = h_reg;

    always_comb
    begin
        c1_next       = '0;
        c1_next.s1    = slope_final(in_data.s1);
        c1_next.s2    = slope_final(in_data.s2);
        c1_next.delta = COEF_W'(in_data.delta);
        c1_next.start = COEF_W'(in_data.start);
        c1_next.hp    = in_data.s1.used;
        c1_next.hn    = in_data.s2.used;
        // a divisor of an unused slope does not count
        c1_next.fault = (in_data.s1.used && in_data.s1.zero)
                     || (in_data.s2.used && in_data.s2.zero);
        c1_next.x     = in_data.x;

        c2_next    = c1_reg;
        c2_next.t1 = cadd(c1_reg.s1, c1_reg.s2);
        c2_next.t2 = cadd(c1_reg.delta, c1_reg.delta);
        c2_next.bl = csub(c1_reg.delta, c1_reg.s1);
        c2_next.br = csub(c1_reg.s2, c1_reg.delta);

        c3_next    = c2_reg;
        c3_next.a3 = csub(c2_reg.t1, c2_reg.t2);
        c3_next.cr = csub(c2_reg.delta, c2_reg.br);

        bc = csub(csub(c3_reg.delta, c3_reg.a3), c3_reg.s1);
        h_next.d     = c3_reg.start;
        h_next.x     = c3_reg.x;
        h_next.fault = c3_reg.fault;
        unique case ({c3_reg.hp, c3_reg.hn})
            2'b11:
            begin
                h_next.acc = c3_reg.a3;
                h_next.b   = bc;
                h_next.c   = c3_reg.s1;
            end
            2'b10:
            begin
                h_next.acc = '0;
                h_next.b   = c3_reg.bl;
                h_next.c   = c3_reg.s1;
            end
            2'b01:
            begin
                h_next.acc = '0;
                h_next.b   = c3_reg.br;
                h_next.c   = c3_reg.cr;
            end
            default:
            begin
                h_next.acc = '0;
                h_next.b   = '0;
                h_next.c   = c3_reg.delta;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            c1_reg <= c1_next;
        if (r2 && v1_reg)
            c2_reg <= c2_next;
        if (r3 && v2_reg)
            c3_reg <= c3_next;
        if (r4 && v3_reg)
            h_reg <= h_next;
    end

endmodule

// ----- src/kci_horner_stage.sv -----
// ----------------------------------------------------------------------------
// kci_horner_stage
// One Horner step: acc*x in one stage, round, add next coefficient, saturate.
// ----------------------------------------------------------------------------
module kci_horner_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kci_pkg::horner_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output kci_pkg::horner_t out_data
);
    import kci_pkg::*;

    logic                   m_valid_reg;
    logic                   a_valid_reg;
    logic                   m_ready;
    horner_t                m_reg;
    logic signed [PX_W-1:0] p_reg;
    logic signed [PX_W-1:0] p_next;
    horner_t                a_reg;
    horner_t                a_next;
    logic signed [PX_W-1:0] rs;
    wide_t                  sum;

    assign m_ready   = !a_valid_reg || out_ready;
    assign in_ready  = !m_valid_reg || m_ready;
    assign out_valid = a_valid_reg;
    assign out_data  = a_reg;

    always_comb
    begin
        p_next = in_data.acc * $signed({1'b0, in_data.x});
        // round half up, then drop the fraction
        rs  = (p_reg + ROUND_HALF) >>> FRAC_BITS;
        sum = wide_t'(rs[COEF_W+1:0]) + wide_t'(m_reg.b);
        a_next     = m_reg;
        a_next.acc = sat_coef(sum);
        a_next.b   = m_reg.c;
        a_next.c   = m_reg.d;
        a_next.d   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                m_valid_reg <= in_valid;
            if (m_ready)
                a_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            m_reg <= in_data;
            p_reg <= p_next;
        end
        if (m_ready && m_valid_reg)
            a_reg <= a_next;
    end

endmodule

// ----- src/keyframe_cubic_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_cubic_interpolator
// Cubic Hermite keyframe interpolation of one Q16.16 channel per item.
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled and returns one result per item, in
// order. The pipeline holds the difference and numerator product registers,
// 33 divider stages retiring two quotient bits each for both slopes, four
// coefficient stages, three Horner steps of two stages each, and the output
// register. Back pressure stalls the pipeline stage by stage, so empty stages
// keep filling while the output waits.
module keyframe_cubic_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_prev,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_start,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_end,
    input  logic signed [kci_pkg::VAL_W-1:0]  time_next,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_prev,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_start,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_end,
    input  logic signed [kci_pkg::VAL_W-1:0]  value_next,
    input  logic                              has_prev,
    input  logic                              has_next,
    input  logic [kci_pkg::FRAC_W-1:0]        frac,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [kci_pkg::VAL_W-1:0]  value_out,
    output logic                              slope_fault
);
    import kci_pkg::*;

    logic                    dv [DIV_STAGES+1];
    logic                    dr [DIV_STAGES+1];
    div_item_t               dd [DIV_STAGES+1];
    logic                    hv [4];
    logic                    hr [4];
    horner_t                 hd [4];
    logic                    o_ready;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next_c;
    logic                    fault_reg;

    kci_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .time_prev   (time_prev),
        .time_start  (time_start),
        .time_end    (time_end),
        .time_next   (time_next),
        .value_prev  (value_prev),
        .value_start (value_start),
        .value_end   (value_end),
        .value_next  (value_next),
        .has_prev    (has_prev),
        .has_next    (has_next),
        .frac        (frac),
        .out_valid   (dv[0]),
        .out_ready   (dr[0]),
        .out_data    (dd[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        kci_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[g]),
            .in_ready  (dr[g]),
            .in_data   (dd[g]),
            .out_valid (dv[g+1]),
            .out_ready (dr[g+1]),
            .out_data  (dd[g+1])
        );
    end

    kci_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv[DIV_STAGES]),
        .in_ready  (dr[DIV_STAGES]),
        .in_data   (dd[DIV_STAGES]),
        .out_valid (hv[0]),
        .out_ready (hr[0]),
        .out_data  (hd[0])
    );

    for (genvar h = 0; h < 3; h++)
    begin : g_horner
        kci_horner_stage u_horner (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (hv[h]),
            .in_ready  (hr[h]),
            .in_data   (hd[h]),
            .out_valid (hv[h+1]),
            .out_ready (hr[h+1]),
            .out_data  (hd[h+1])
        );
    end

    assign o_ready     = !out_valid_reg || out_ready;
    assign hr[3]       = o_ready;
    assign out_valid   = out_valid_reg;
    assign value_out   = value_reg;
    assign slope_fault = fault_reg;

    // final saturation to the output width
    always_comb
    begin
        if (hd[3].acc > coef_t'({1'b0, {(VAL_W-1){1'b1}}}))
            value_next_c = {1'b0, {(VAL_W-1){1'b1}}};
        else if (hd[3].acc < $signed({{(COEF_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}}))
            value_next_c = {1'b1, {(VAL_W-1){1'b0}}};
        else
            value_next_c = hd[3].acc[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (o_ready)
            out_valid_reg <= hv[3];
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && hv[3])
        begin
            value_reg <= value_next_c;
            fault_reg <= hd[3].fault;
        end
    end

`ifndef SYNTHESIS
    // the input side blocks only when every stage is full behind a stalled output
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back pressure");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> u_prep.a_valid_reg)
        else $error("transfer lost at pipeline entry");

    a_frac_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        hv[0] |-> (hd[0].x <= FRAC_ONE))
        else $error("fraction above one reached the evaluator");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(value_out) && $stable(slope_fault)))
        else $error("result changed while waiting");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({value_out, slope_fault}))
        else $error("result has unknown bits");
`endif

endmodule

// ----- test/tb_keyframe_cubic_interpolator.sv -----
// ----------------------------------------------------------------------------
// tb_keyframe_cubic_interpolator
// Self-checking bench for the keyframe cubic interpolator: an in-bench
// predictor computes the Hermite curve value and the slope fault for every
// transfer, and the results are checked in order under random stalls.
// ----------------------------------------------------------------------------
module tb_keyframe_cubic_interpolator;

    import kci_pkg::*;

    localparam longint COEF_MAX  = (longint'(1) <<< (COEF_W - 1)) - 1;
    localparam longint VAL_MAX   = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam int     LIMIT     = 400000;
    localparam int     DRAIN_GAP = 60;

    typedef struct {
        logic signed [VAL_W-1:0] t_prev, t_start, t_end, t_next;
        logic signed [VAL_W-1:0] v_prev, v_start, v_end, v_next;
        logic                    has_prev, has_next;
        logic [FRAC_W-1:0]       frac;
    } key_seg_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    fault;
    } curve_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [VAL_W-1:0] time_prev = '0, time_start = '0, time_end = '0, time_next = '0;
    logic signed [VAL_W-1:0] value_prev = '0, value_start = '0, value_end = '0, value_next = '0;
    logic has_prev = 1'b0, has_next = 1'b0;
    logic [FRAC_W-1:0] frac = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VAL_W-1:0] value_out;
    logic slope_fault;

    curve_pt_t pending_pts[$];
    int  send_idle = 0;
    int  recv_idle = 0;
    int  errors = 0;
    int  sent = 0;
    int  checked = 0;
    int  faults_seen = 0;
    int  cycles = 0;

    keyframe_cubic_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .time_prev(time_prev), .time_start(time_start),
        .time_end(time_end), .time_next(time_next),
        .value_prev(value_prev), .value_start(value_start),
        .value_end(value_end), .value_next(value_next),
        .has_prev(has_prev), .has_next(has_next), .frac(frac),
        .out_valid(out_valid), .out_ready(out_ready),
        .value_out(value_out), .slope_fault(slope_fault)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint hi);
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // num * mul / den truncated toward zero, saturated to the coefficient range
    function automatic longint scaled_quot(longint num, longint mul, longint den);
        logic [127:0] p;
        logic [127:0] q;
        longint an, am, ad;
        bit neg;
        an = (num < 0) ? -num : num;
        am = (mul < 0) ? -mul : mul;
        ad = (den < 0) ? -den : den;
        neg = ((num < 0) != (mul < 0)) != (den < 0);
        p = 128'(an) * 128'(am);
        q = p / 128'(ad);
        if (neg)
            return (q > 128'(COEF_MAX + 1)) ? -COEF_MAX - 1 : -longint'(q[63:0]);
        return (q > 128'(COEF_MAX)) ? COEF_MAX : longint'(q[63:0]);
    endfunction

    function automatic curve_pt_t predict_curve(key_seg_t s);
        curve_pt_t r;
        longint dt, delta, den, a, b, c, d, s1, s2, x, acc;
        bit flt;
        flt = 1'b0;
        s1 = 0;
        s2 = 0;
        a = 0;
        b = 0;
        dt = longint'(s.t_end) - longint'(s.t_start);
        delta = longint'(s.v_end) - longint'(s.v_start);
        d = longint'(s.v_start);
        x = (s.frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(s.frac);
        if (s.has_prev)
        begin
            den = longint'(s.t_end) - longint'(s.t_prev);
            if (den == 0)
                flt = 1'b1;
            else
                s1 = scaled_quot(longint'(s.v_end) - longint'(s.v_prev), dt, den);
        end
        if (s.has_next)
        begin
            den = longint'(s.t_next) - longint'(s.t_start);
            if (den == 0)
                flt = 1'b1;
            else
                s2 = scaled_quot(longint'(s.v_next) - longint'(s.v_start), dt, den);
        end
        if (s.has_prev && s.has_next)
        begin
            c = s1;
            a = clamp_to(clamp_to(s1 + s2, COEF_MAX) - clamp_to(2 * delta, COEF_MAX), COEF_MAX);
            b = clamp_to(clamp_to(delta - a, COEF_MAX) - c, COEF_MAX);
        end
        else if (s.has_prev)
        begin
            c = s1;
            b = clamp_to(delta - s1, COEF_MAX);
        end
        else if (s.has_next)
        begin
            b = clamp_to(s2 - delta, COEF_MAX);
            c = clamp_to(delta - b, COEF_MAX);
        end
        else
            c = delta;
        acc = clamp_to((((a * x) + 32768) >>> FRAC_BITS) + b, COEF_MAX);
        acc = clamp_to((((acc * x) + 32768) >>> FRAC_BITS) + c, COEF_MAX);
        acc = clamp_to((((acc * x) + 32768) >>> FRAC_BITS) + d, COEF_MAX);
        r.value = VAL_W'(clamp_to(acc, VAL_MAX));
        r.fault = flt;
        return r;
    endfunction

    // one transfer, optionally preceded by sender idle cycles
    task automatic send_segment(key_seg_t s);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        time_prev   <= s.t_prev;
        time_start  <= s.t_start;
        time_end    <= s.t_end;
        time_next   <= s.t_next;
        value_prev  <= s.v_prev;
        value_start <= s.v_start;
        value_end   <= s.v_end;
        value_next  <= s.v_next;
        has_prev    <= s.has_prev;
        has_next    <= s.has_next;
        frac        <= s.frac;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pts.push_back(predict_curve(s));
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    function automatic key_seg_t make_seg(int tp, int ts, int te, int tn, int vp, int vs,
                                          int ve, int vn, bit hp, bit hn, int fr);
        key_seg_t s;
        s.t_prev = tp; s.t_start = ts; s.t_end = te; s.t_next = tn;
        s.v_prev = vp; s.v_start = vs; s.v_end = ve; s.v_next = vn;
        s.has_prev = hp; s.has_next = hn; s.frac = FRAC_W'(fr);
        return s;
    endfunction

    function automatic key_seg_t random_segment();
        key_seg_t s;
        int t0;
        int kind;
        kind = $urandom_range(99);
        s.has_prev = $urandom_range(1);
        s.has_next = $urandom_range(1);
        case ($urandom_range(5))
            0: s.frac = $urandom_range(131071);
            1: s.frac = FRAC_ONE;
            2: s.frac = 0;
            default: s.frac = $urandom_range(65536);
        endcase
        if (kind < 20)
        begin
            // fully random fields, reversed and huge spans included
            s.t_prev = $urandom; s.t_start = $urandom; s.t_end = $urandom; s.t_next = $urandom;
            s.v_prev = $urandom; s.v_start = $urandom; s.v_end = $urandom; s.v_next = $urandom;
        end
        else
        begin
            // ordered keyframes with moderate spacing
            t0 = $urandom_range(200000) - 100000;
            s.t_prev  = t0 << 8;
            s.t_start = s.t_prev + $urandom_range(1 << 20);
            s.t_end   = s.t_start + $urandom_range(1 << 20);
            s.t_next  = s.t_end + $urandom_range(1 << 20);
            s.v_prev  = $signed($urandom) >>> $urandom_range(16);
            s.v_start = $signed($urandom) >>> $urandom_range(16);
            s.v_end   = $signed($urandom) >>> $urandom_range(16);
            s.v_next  = $signed($urandom) >>> $urandom_range(16);
            if (kind < 28)
                s.t_prev = s.t_end;
            else if (kind < 36)
                s.t_next = s.t_start;
        end
        return s;
    endfunction

    // check every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        curve_pt_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pts.size() == 0)
            begin
                $error("result with no prediction waiting: value_out=%0d", value_out);
                errors++;
            end
            else
            begin
                e = pending_pts.pop_front();
                checked++;
                if (slope_fault)
                    faults_seen++;
                if (value_out !== e.value)
                begin
                    $error("value_out expected %0d got %0d", e.value, value_out);
                    errors++;
                end
                if (slope_fault !== e.fault)
                begin
                    $error("slope_fault expected %0d got %0d", e.fault, slope_fault);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_curve_forms();
        int mx;
        int mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        // linear, both quadratics, cubic on a regular segment
        send_segment(make_seg(0, 65536, 131072, 196608, 0, 65536, 131072, 65536, 0, 0, 32768));
        send_segment(make_seg(0, 65536, 131072, 196608, 0, 65536, 131072, 65536, 1, 0, 32768));
        send_segment(make_seg(0, 65536, 131072, 196608, 0, 65536, 131072, 65536, 0, 1, 32768));
        send_segment(make_seg(0, 65536, 131072, 196608, 0, 65536, 131072, 65536, 1, 1, 32768));
        // frac ends and clamp above one
        send_segment(make_seg(0, 65536, 131072, 196608, 5, -65536, 131072, 7, 1, 1, 0));
        send_segment(make_seg(0, 65536, 131072, 196608, 5, -65536, 131072, 7, 1, 1, 65536));
        send_segment(make_seg(0, 65536, 131072, 196608, 5, -65536, 131072, 7, 1, 1, 131071));
        send_segment(make_seg(0, 65536, 131072, 196608, 5, -65536, 131072, 7, 1, 1, 65537));
        // zero divisors, used and unused
        send_segment(make_seg(131072, 65536, 131072, 196608, 0, 0, 65536, 0, 1, 0, 40000));
        send_segment(make_seg(0, 65536, 131072, 65536, 0, 0, 65536, 0, 0, 1, 40000));
        send_segment(make_seg(131072, 65536, 131072, 65536, 0, 0, 65536, 0, 1, 1, 40000));
        send_segment(make_seg(131072, 65536, 131072, 65536, 0, 0, 65536, 0, 0, 0, 40000));
        // huge slopes, field extremes, reversed times
        send_segment(make_seg(mx - 1, mn, mx, mn, mn, mn, mx, mx, 1, 1, 30000));
        send_segment(make_seg(mx, mn, mn + 1, mn + 1, mx, mx, mn, mn, 1, 1, 50000));
        send_segment(make_seg(mx, mx, mx, mx, mx, mx, mx, mx, 1, 1, 65535));
        send_segment(make_seg(mn, mn, mn, mn, mn, mn, mn, mn, 1, 1, 1));
        send_segment(make_seg(mn, mx, mn, mx, mx, mn, mx, mn, 1, 1, 65536));
        send_segment(make_seg(300000, 200000, 100000, 0, 9, -700000, 800000, -5, 1, 1, 20000));
        send_segment(make_seg(-1, 0, 1, 2, mn, mx, mn, mx, 1, 1, 32768));
        send_segment(make_seg(0, 1, 0, -1, -3, 3, -3, 3, 1, 1, 12345));
    endtask

    task automatic test_random_segments(int count);
        repeat (count)
            send_segment(random_segment());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 33;
        recv_idle = 68;
        test_curve_forms();
        drain_results();
        test_random_segments(600);
        drain_results();

        send_idle = 68;
        recv_idle = 33;
        test_random_segments(600);
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        test_random_segments(600);
        drain_results();

        $display("covered %0d transfers in four curve forms with stalls on both sides", sent);
        $display("checked %0d results, %0d of them with a slope fault", checked, faults_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
